// File: rtl/core/pogt_pkg.sv
`default_nettype none
package pogt_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int PADDR_W       = 4;
    localparam int DATA_W        = 32;

    // Register map, by word index
    localparam logic [1:0] CFG_IDX_MIN_OFF    = 2'd0;
    localparam logic [1:0] CFG_IDX_MAX_ON     = 2'd1;
    localparam logic [1:0] CFG_IDX_SOFT_START = 2'd2;

    localparam logic [31:0] MIN_OFF_RST    = 32'd10000;
    localparam logic [31:0] MAX_ON_RST     = 32'd300000;
    localparam logic [31:0] SOFT_START_RST = 32'd0;

    // Command codes; 5 to 7 are unused
    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_ON     = 3'd1;
    localparam logic [2:0] MODE_OFF    = 3'd2;
    localparam logic [2:0] MODE_TOGGLE = 3'd3;
    localparam logic [2:0] MODE_TIMED  = 3'd4;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_STARTED     = 3'd1,
        EV_IGNORED_ON  = 3'd2,
        EV_BLOCKED     = 3'd3,
        EV_STOPPED     = 3'd4,
        EV_IGNORED_OFF = 3'd5,
        EV_TIMED_DONE  = 3'd6,
        EV_TIMEOUT     = 3'd7
    } t_event;

    typedef struct packed {
        logic [31:0] min_off_ms;
        logic [31:0] max_on_ms;
        logic [31:0] soft_start_ms;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] run_length_ms;
    } t_cmd;

    typedef struct packed {
        logic        gate;
        logic        running;
        t_event      event_res;
        logic [31:0] session_ms;
        logic [31:0] total_on_ms;
    } t_result;

endpackage
`default_nettype wire

// File: rtl/core/pogt_cmd_if.sv
`default_nettype none
interface pogt_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [31:0] run_length_ms;

    modport source (output valid, output mode, output run_length_ms, input ready);
    modport sink   (input valid, input mode, input run_length_ms, output ready);
endinterface
`default_nettype wire

// File: rtl/core/pogt_res_if.sv
`default_nettype none
interface pogt_res_if;
    logic        valid;
    logic        ready;
    logic        gate;
    logic        running;
    logic [2:0]  event_res;
    logic [31:0] session_ms;
    logic [31:0] total_on_ms;

    modport source (output valid, output gate, output running, output event_res,
                    output session_ms, output total_on_ms, input ready);
    modport sink   (input valid, input gate, input running, input event_res,
                    input session_ms, input total_on_ms, output ready);
endinterface
`default_nettype wire

// File: rtl/core/pogt_ctrl.sv
`default_nettype none
// Pump state and guard timers; advances one command per i_step.
module pogt_ctrl #(
    parameter int TIME_BITS = pogt_pkg::TIME_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire pogt_pkg::t_cmd    i_cmd,
    input  wire pogt_pkg::t_cfg    i_cfg,
    output pogt_pkg::t_result      o_res
);

    localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    logic                 r_on, n_on;
    logic                 r_in_ss, n_in_ss;
    logic                 r_armed, n_armed;
    logic [TIME_BITS-1:0] r_ss_left, n_ss_left;
    logic [TIME_BITS-1:0] r_on_el, n_on_el;
    logic [TIME_BITS-1:0] r_off_el, n_off_el;
    logic [TIME_BITS-1:0] r_timed_len, n_timed_len;
    logic [TIME_BITS-1:0] r_last, n_last;
    logic [TIME_BITS-1:0] r_total, n_total;

    logic                 do_off;
    logic                 try_on;
    logic                 arm_req;
    logic                 min_off_ok;
    pogt_pkg::t_event     ev;

    assign min_off_ok = !(CMP_W'(r_off_el) < CMP_W'(i_cfg.min_off_ms));

    always_comb begin
        n_on        = r_on;
        n_in_ss     = r_in_ss;
        n_armed     = r_armed;
        n_ss_left   = r_ss_left;
        n_on_el     = r_on_el;
        n_off_el    = r_off_el;
        n_timed_len = r_timed_len;
        n_last      = r_last;
        n_total     = r_total;
        do_off      = 1'b0;
        try_on      = 1'b0;
        arm_req     = 1'b0;
        ev          = pogt_pkg::EV_NONE;

        if (i_cmd.mode == pogt_pkg::MODE_TICK) begin
            if (!r_on) begin
                if (r_off_el != TMAX) n_off_el = r_off_el + TIME_BITS'(1);
            end else begin
                if (r_on_el != TMAX) n_on_el = r_on_el + TIME_BITS'(1);
                if (r_in_ss) begin
                    if (r_ss_left != '0) n_ss_left = r_ss_left - TIME_BITS'(1);
                    n_in_ss = (n_ss_left != '0);
                end
                // guards apply once soft start is over, including its last tick
                if (!n_in_ss) begin
                    if (r_armed && (n_on_el >= r_timed_len)) begin
                        do_off = 1'b1;
                        ev     = pogt_pkg::EV_TIMED_DONE;
                    end else if (CMP_W'(n_on_el) >= CMP_W'(i_cfg.max_on_ms)) begin
                        do_off = 1'b1;
                        ev     = pogt_pkg::EV_TIMEOUT;
                    end
                end
            end
        end else if (r_in_ss) begin
            case (i_cmd.mode)
                pogt_pkg::MODE_OFF, pogt_pkg::MODE_TOGGLE: ev = pogt_pkg::EV_IGNORED_OFF;
                pogt_pkg::MODE_ON, pogt_pkg::MODE_TIMED:   ev = pogt_pkg::EV_IGNORED_ON;
                default:                                   ev = pogt_pkg::EV_NONE;
            endcase
        end else begin
            case (i_cmd.mode)
                pogt_pkg::MODE_ON: begin
                    if (r_on) ev = pogt_pkg::EV_IGNORED_ON;
                    else      try_on = 1'b1;
                end
                pogt_pkg::MODE_OFF: begin
                    if (r_on) begin
                        do_off = 1'b1;
                        ev     = pogt_pkg::EV_STOPPED;
                    end else begin
                        ev = pogt_pkg::EV_IGNORED_OFF;
                    end
                end
                pogt_pkg::MODE_TOGGLE: begin
                    if (r_on) begin
                        do_off = 1'b1;
                        ev     = pogt_pkg::EV_STOPPED;
                    end else begin
                        try_on = 1'b1;
                    end
                end
                pogt_pkg::MODE_TIMED: begin
                    if (r_on) ev = pogt_pkg::EV_IGNORED_ON;
                    else begin
                        try_on  = 1'b1;
                        arm_req = 1'b1;
                    end
                end
                default: ev = pogt_pkg::EV_NONE;
            endcase
        end

        if (try_on) begin
            if (!min_off_ok) begin
                ev = pogt_pkg::EV_BLOCKED;
            end else begin
                ev        = pogt_pkg::EV_STARTED;
                n_on      = 1'b1;
                n_on_el   = '0;
                n_ss_left = TIME_BITS'(i_cfg.soft_start_ms);
                n_in_ss   = (n_ss_left != '0);
                if (arm_req) begin
                    n_armed     = 1'b1;
                    n_timed_len = TIME_BITS'(i_cmd.run_length_ms);
                end
            end
        end

        if (do_off) begin
            n_last    = n_on_el;
            n_total   = r_total + n_on_el;
            n_on      = 1'b0;
            n_in_ss   = 1'b0;
            n_ss_left = '0;
            n_armed   = 1'b0;
            n_off_el  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on        <= 1'b0;
            r_in_ss     <= 1'b0;
            r_armed     <= 1'b0;
            r_ss_left   <= '0;
            r_on_el     <= '0;
            r_off_el    <= '0;
            r_timed_len <= '0;
            r_last      <= '0;
            r_total     <= '0;
        end else if (i_step) begin
            r_on        <= n_on;
            r_in_ss     <= n_in_ss;
            r_armed     <= n_armed;
            r_ss_left   <= n_ss_left;
            r_on_el     <= n_on_el;
            r_off_el    <= n_off_el;
            r_timed_len <= n_timed_len;
            r_last      <= n_last;
            r_total     <= n_total;
        end
    end

    always_comb begin
        o_res.gate        = n_on && !n_in_ss;
        o_res.running     = n_on;
        o_res.event_res   = ev;
        o_res.session_ms  = 32'(n_last);
        o_res.total_on_ms = 32'(n_total);
    end

endmodule
`default_nettype wire

// File: rtl/core/pump_on_off_guard_timer_core.sv
// Pump gate controller with minimum off time, soft start and on-time limit.
// Every command transaction (1 ms tick, on, off, toggle, timed run) yields
// exactly one result transaction carrying the gate level, the running flag,
// an event code, the last session length and the accumulated on time. A
// command is held in an input register and then passes the update logic that
// writes the state and the result register together, so the block sustains
// one transaction per clock while the result sink is ready; the result is held
// in the result register until the sink takes it. The pace is set only by the
// single state update per cycle and by the result sink's ready. Configuration
// (min off, max on, soft start) is written through the APB port at byte
// addresses 0, 4 and 8, and should be changed only while no transaction is in
// flight. Counters are TIME_BITS wide; the reported times are their low 32 bits.
`default_nettype none
module pump_on_off_guard_timer_core #(
    parameter int TIME_BITS = pogt_pkg::TIME_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    pogt_cmd_if.sink                           i_cmd,
    pogt_res_if.source                         o_res,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pogt_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [pogt_pkg::DATA_W-1:0]   pwdata,
    output logic      [pogt_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);

    // configuration registers
    pogt_pkg::t_cfg    r_cfg;
    logic              cfg_wr;
    logic [1:0]        cfg_idx;

    // input stage
    logic              r_in_valid;
    pogt_pkg::t_cmd    r_in_cmd;

    // result stage
    logic              r_out_valid;
    pogt_pkg::t_result r_out;
    pogt_pkg::t_result n_out;

    logic              advance;

    // APB: no wait states; word index from paddr
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_off_ms    <= pogt_pkg::MIN_OFF_RST;
            r_cfg.max_on_ms     <= pogt_pkg::MAX_ON_RST;
            r_cfg.soft_start_ms <= pogt_pkg::SOFT_START_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                pogt_pkg::CFG_IDX_MIN_OFF:    r_cfg.min_off_ms    <= pwdata;
                pogt_pkg::CFG_IDX_MAX_ON:     r_cfg.max_on_ms     <= pwdata;
                pogt_pkg::CFG_IDX_SOFT_START: r_cfg.soft_start_ms <= pwdata;
                default: ;  // write beyond the map: drop
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            pogt_pkg::CFG_IDX_MIN_OFF:    prdata = r_cfg.min_off_ms;
            pogt_pkg::CFG_IDX_MAX_ON:     prdata = r_cfg.max_on_ms;
            pogt_pkg::CFG_IDX_SOFT_START: prdata = r_cfg.soft_start_ms;
            default:                      prdata = '0;
        endcase
    end

    // Advance the held command whenever the result register is free or
    // being drained this cycle; the input register refills in the same cycle.
    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in_cmd.mode          <= i_cmd.mode;
            r_in_cmd.run_length_ms <= i_cmd.run_length_ms;
        end
    end

    pogt_ctrl #(
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_cmd   (r_in_cmd),
        .i_cfg   (r_cfg),
        .o_res   (n_out)
    );

    // Result register: load on advance, hold while the sink stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.gate        = r_out.gate;
    assign o_res.running     = r_out.running;
    assign o_res.event_res   = r_out.event_res;
    assign o_res.session_ms  = r_out.session_ms;
    assign o_res.total_on_ms = r_out.total_on_ms;

    // The gate never drives while the pump is logically off.
    a_gate_needs_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.gate |-> r_out.running)
        else $error("gate high while pump not running");

    // A start leaves the pump running; any switch-off leaves it stopped.
    a_start_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.event_res == pogt_pkg::EV_STARTED) |-> r_out.running)
        else $error("start event without running pump");

    a_stop_not_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.event_res == pogt_pkg::EV_STOPPED
                     || r_out.event_res == pogt_pkg::EV_TIMED_DONE
                     || r_out.event_res == pogt_pkg::EV_TIMEOUT)
        |-> !r_out.running && !r_out.gate)
        else $error("switch-off event with pump still on");

    // Every advanced command must show up as a valid result next cycle.
    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("advanced command produced no result");

endmodule
`default_nettype wire

// File: verif/pump_on_off_guard_timer_checker.sv
`default_nettype none
module pump_on_off_guard_timer_checker
    import pogt_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    pogt_cmd_if                      i_cmd,
    pogt_res_if                      i_res,
    input  wire logic                i_psel,
    input  wire logic                i_penable,
    input  wire logic                i_pwrite,
    input  wire logic [PADDR_W-1:0]  i_paddr,
    input  wire logic [DATA_W-1:0]   i_pwdata,
    input  wire logic [DATA_W-1:0]   i_prdata,
    input  wire logic                i_pready,
    output int                       o_fail_count,
    output int                       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 40;

    // Register copies
    logic [31:0] min_off_cfg;
    logic [31:0] max_on_cfg;
    logic [31:0] soft_start_cfg;

    // Pump state
    logic        pump_on;
    logic        soft_active;
    logic [31:0] soft_left;
    logic [31:0] on_ms;
    logic [31:0] off_ms;
    logic        run_armed;
    logic [31:0] run_len;
    logic [31:0] last_session_ms;
    logic [31:0] total_ms;

    t_result     expected_results[$];
    int          fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic flag(input string what, input logic [31:0] exp_v, input logic [31:0] act_v);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t mismatch %s: expected %0h actual %0h", $time, what, exp_v, act_v);
    endtask

    function automatic void stop_pump();
        last_session_ms = on_ms;
        total_ms        = total_ms + on_ms;
        pump_on         = 1'b0;
        soft_active     = 1'b0;
        soft_left       = '0;
        run_armed       = 1'b0;
        off_ms          = '0;
    endfunction

    function automatic t_event try_start();
        if (off_ms < min_off_cfg)
            return EV_BLOCKED;
        pump_on     = 1'b1;
        on_ms       = '0;
        soft_left   = soft_start_cfg;
        soft_active = (soft_start_cfg != '0);
        return EV_STARTED;
    endfunction

    function automatic t_result step_pump(input logic [2:0] mode, input logic [31:0] len);
        t_event  ev;
        t_result r;
        ev = EV_NONE;
        if (mode == MODE_TICK) begin
            if (!pump_on) begin
                if (off_ms != '1)
                    off_ms++;
            end else begin
                if (on_ms != '1)
                    on_ms++;
                if (soft_active) begin
                    if (soft_left != '0)
                        soft_left--;
                    if (soft_left == '0)
                        soft_active = 1'b0;
                end
                // guards run on the tick that ends soft start as well
                if (!soft_active) begin
                    if (run_armed && on_ms >= run_len) begin
                        stop_pump();
                        ev = EV_TIMED_DONE;
                    end else if (on_ms >= max_on_cfg) begin
                        stop_pump();
                        ev = EV_TIMEOUT;
                    end
                end
            end
        end else if (mode <= MODE_TIMED) begin
            if (soft_active) begin
                if (mode == MODE_OFF || mode == MODE_TOGGLE)
                    ev = EV_IGNORED_OFF;
                else
                    ev = EV_IGNORED_ON;
            end else begin
                case (mode)
                    MODE_ON: begin
                        if (pump_on)
                            ev = EV_IGNORED_ON;
                        else
                            ev = try_start();
                    end
                    MODE_OFF: begin
                        if (pump_on) begin
                            stop_pump();
                            ev = EV_STOPPED;
                        end else begin
                            ev = EV_IGNORED_OFF;
                        end
                    end
                    MODE_TOGGLE: begin
                        if (pump_on) begin
                            stop_pump();
                            ev = EV_STOPPED;
                        end else begin
                            ev = try_start();
                        end
                    end
                    MODE_TIMED: begin
                        if (pump_on) begin
                            ev = EV_IGNORED_ON;
                        end else begin
                            ev = try_start();
                            if (ev == EV_STARTED) begin
                                run_armed = 1'b1;
                                run_len   = len;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
        r.gate        = pump_on && !soft_active;
        r.running     = pump_on;
        r.event_res   = ev;
        r.session_ms  = last_session_ms;
        r.total_on_ms = total_ms;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result     exp_r;
        logic [31:0] cfg_rd;
        if (!i_rst_n) begin
            min_off_cfg     = MIN_OFF_RST;
            max_on_cfg      = MAX_ON_RST;
            soft_start_cfg  = SOFT_START_RST;
            pump_on         = 1'b0;
            soft_active     = 1'b0;
            soft_left       = '0;
            on_ms           = '0;
            off_ms          = '0;
            run_armed       = 1'b0;
            run_len         = '0;
            last_session_ms = '0;
            total_ms        = '0;
            expected_results.delete();
            o_pending <= 0;
        end else begin
            if (i_psel && i_penable && i_pready) begin
                case (i_paddr[3:2])
                    CFG_IDX_MIN_OFF:    cfg_rd = min_off_cfg;
                    CFG_IDX_MAX_ON:     cfg_rd = max_on_cfg;
                    CFG_IDX_SOFT_START: cfg_rd = soft_start_cfg;
                    default:            cfg_rd = '0;
                endcase
                if (i_pwrite) begin
                    case (i_paddr[3:2])
                        CFG_IDX_MIN_OFF:    min_off_cfg    = i_pwdata;
                        CFG_IDX_MAX_ON:     max_on_cfg     = i_pwdata;
                        CFG_IDX_SOFT_START: soft_start_cfg = i_pwdata;
                        default: ;
                    endcase
                end else if (i_prdata !== cfg_rd) begin
                    flag("register readback", cfg_rd, i_prdata);
                end
            end

            if (i_res.valid && i_res.ready) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t unexpected result transaction: expected none, got event %0d",
                                 $time, i_res.event_res);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (i_res.gate !== exp_r.gate)
                        flag("gate", exp_r.gate, i_res.gate);
                    if (i_res.running !== exp_r.running)
                        flag("running", exp_r.running, i_res.running);
                    if (i_res.event_res !== exp_r.event_res)
                        flag("event_res", exp_r.event_res, i_res.event_res);
                    if (i_res.session_ms !== exp_r.session_ms)
                        flag("session_ms", exp_r.session_ms, i_res.session_ms);
                    if (i_res.total_on_ms !== exp_r.total_on_ms)
                        flag("total_on_ms", exp_r.total_on_ms, i_res.total_on_ms);
                end
            end

            if (i_cmd.valid && i_cmd.ready)
                expected_results.push_back(step_pump(i_cmd.mode, i_cmd.run_length_ms));

            o_pending <= expected_results.size();
        end
    end
endmodule
`default_nettype wire

// File: verif/pump_on_off_guard_timer_core_tb.sv
`default_nettype none
module pump_on_off_guard_timer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pogt_pkg::*;

    localparam int          N_PHASES    = 14;
    localparam int          PHASE_ITEMS = 125;
    localparam int          WAIT_LIMIT  = 100000;
    // codes above the timed run carry no command
    localparam logic [2:0]  MODE_FIRST_SPARE = MODE_TIMED + 3'd1;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    int                   fail_count;
    int                   pending;
    int                   src_idle_pct  = 0;
    int                   snk_stall_pct = 0;

    pogt_cmd_if cmd_ch ();
    pogt_res_if res_ch ();

    pump_on_off_guard_timer_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pump_on_off_guard_timer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_res        (res_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result sink: stall at random, at the rate the current phase asks
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Hard stop well beyond the slowest passing run
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // One APB transfer: setup phase and access phase, then psel is dropped so
    // back-to-back calls never reassign psel within one time step.
    task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write all three registers, then read them back for the checker.
    task automatic configure(input logic [31:0] min_off, input logic [31:0] max_on,
                             input logic [31:0] soft_start);
        apb_access(1'b1, CFG_IDX_MIN_OFF,    min_off);
        apb_access(1'b1, CFG_IDX_MAX_ON,     max_on);
        apb_access(1'b1, CFG_IDX_SOFT_START, soft_start);
        apb_access(1'b0, CFG_IDX_MIN_OFF,    '0);
        apb_access(1'b0, CFG_IDX_MAX_ON,     '0);
        apb_access(1'b0, CFG_IDX_SOFT_START, '0);
    endtask

    // Present one command and hold it until the block takes it. Valid is
    // dropped only while idling, so it stays high across back-to-back items.
    task automatic send_cmd(input logic [2:0] mode, input logic [31:0] len);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.mode          <= mode;
        cmd_ch.run_length_ms <= len;
        do @(posedge i_clk); while (!cmd_ch.ready);
    endtask

    // Drop valid and hold off until every result transaction has arrived.
    task automatic wait_all_results();
        int guard;
        guard = 0;
        cmd_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (pending != 0 && guard < WAIT_LIMIT);
    endtask

    // Mostly ticks so pump sessions actually run through soft start and the
    // guards; commands and the odd spare code fill the rest.
    task automatic send_random();
        int          r;
        logic [2:0]  mode;
        logic [31:0] len;
        r   = $urandom_range(99);
        len = $urandom;
        if (r < 55) begin
            mode = MODE_TICK;
        end else if (r < 65) begin
            mode = MODE_ON;
        end else if (r < 73) begin
            mode = MODE_OFF;
        end else if (r < 81) begin
            mode = MODE_TOGGLE;
        end else if (r < 95) begin
            mode = MODE_TIMED;
            r    = $urandom_range(9);
            if (r < 7)
                len = $urandom_range(20);
            else if (r < 9)
                len = $urandom_range(300, 21);
        end else begin
            mode = MODE_FIRST_SPARE + 3'($urandom_range(2));
        end
        send_cmd(mode, len);
    endtask

    initial begin
        logic [31:0] min_off;
        logic [31:0] max_on;
        logic [31:0] soft_start;

        // Every block input known from time zero
        i_rst_n              <= 1'b0;
        cmd_ch.valid         <= 1'b0;
        cmd_ch.mode          <= MODE_TICK;
        cmd_ch.run_length_ms <= '0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: min off time far away, so every switch-on is refused
        send_cmd(MODE_ON, '0);
        send_cmd(MODE_TIMED, '0);
        send_cmd(MODE_OFF, '1);
        send_cmd(MODE_TOGGLE, '0);
        send_cmd(MODE_FIRST_SPARE, '0);
        send_cmd(MODE_FIRST_SPARE + 3'd1, '1);
        send_cmd(MODE_FIRST_SPARE + 3'd2, '0);
        send_cmd(MODE_TICK, '0);
        wait_all_results();

        // Soft start of two ticks; a zero-length timed run ends on the tick
        // that closes soft start. Commands during soft start are ignored.
        configure('0, '1, 32'd2);
        send_cmd(MODE_TIMED, '0);
        send_cmd(MODE_ON, '0);
        send_cmd(MODE_TOGGLE, '0);
        send_cmd(MODE_TICK, '0);
        send_cmd(MODE_TICK, '0);
        wait_all_results();

        // No soft start, short max on time: redundant commands, timeout, stop
        configure('0, 32'd3, '0);
        send_cmd(MODE_ON, '0);
        send_cmd(MODE_ON, '0);
        send_cmd(MODE_TIMED, 32'd5);
        send_cmd(MODE_TICK, '0);
        send_cmd(MODE_TICK, '0);
        send_cmd(MODE_TICK, '0);
        send_cmd(MODE_OFF, '0);
        send_cmd(MODE_TIMED, '1);
        send_cmd(MODE_TOGGLE, '0);
        wait_all_results();

        // Min off time of one tick and zero max on time
        configure(32'd1, '0, '0);
        send_cmd(MODE_ON, '0);
        send_cmd(MODE_TICK, '0);
        send_cmd(MODE_ON, '0);
        send_cmd(MODE_TICK, '0);
        wait_all_results();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            // Sink stalling often, then sender idling often, then flat out
            if (ph < 5) begin
                src_idle_pct  = 7;
                snk_stall_pct = 77;
            end else if (ph < 10) begin
                src_idle_pct  = 77;
                snk_stall_pct = 7;
            end else begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end

            case ($urandom_range(5))
                0:       min_off = '0;
                4:       min_off = $urandom_range(40, 13);
                5:       min_off = '1;
                default: min_off = $urandom_range(12, 1);
            endcase
            case ($urandom_range(5))
                0:       max_on = '0;
                4:       max_on = $urandom;
                5:       max_on = '1;
                default: max_on = $urandom_range(30, 1);
            endcase
            case ($urandom_range(3))
                0, 1:    soft_start = '0;
                default: soft_start = $urandom_range(4, 1);
            endcase
            // Endless soft start locks the pump on, so it goes last
            if (ph == N_PHASES - 1) begin
                min_off    = '0;
                soft_start = '1;
            end

            configure(min_off, max_on, soft_start);
            repeat (PHASE_ITEMS) send_random();
            wait_all_results();
        end

        // Latency tail before the verdict
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
